// ===== hdl/bat_pkg.sv =====
// Shared types and constants for the buddy allocator tree.
// Depends on nothing; the channel interfaces and the top level use it.
`timescale 1ns / 1ps

package bat_pkg;

   localparam int TOP_LEVEL  = 10;
   localparam int UNIT_BYTES = 1;

   localparam int NODE_COUNT = (1 << (TOP_LEVEL + 1)) - 1;
   localparam int NODE_W     = TOP_LEVEL + 1;
   localparam int LVL_W      = $clog2(TOP_LEVEL + 1);
   localparam int UNIT_W     = TOP_LEVEL + 1;
   localparam int UB_BITS    = $clog2(UNIT_BYTES + 1);
   localparam int ADDR_W     = 10;
   localparam int SIZE_W     = 16;
   localparam int BYTE_W     = (UNIT_W + UB_BITS > ADDR_W) ? UNIT_W + UB_BITS : ADDR_W + 1;

   localparam logic [1:0] ST_UNAVAIL = 2'd0;
   localparam logic [1:0] ST_ALLOC   = 2'd1;
   localparam logic [1:0] ST_IDLE    = 2'd2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [SIZE_W-1:0] request_size;
      logic [ADDR_W-1:0] block_address;
   } req_word_type;

   typedef struct packed {
      logic [ADDR_W-1:0] granted_address;
      logic              success;
   } rsp_word_type;

endpackage

// ===== hdl/bat_channels.sv =====
// Valid/ready channel interfaces for request and response words.
// Depends on bat_pkg for the word types.
`timescale 1ns / 1ps

interface bat_req_if;
   logic                  valid;
   logic                  ready;
   bat_pkg::req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface bat_rsp_if;
   logic                  valid;
   logic                  ready;
   bat_pkg::rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

// ===== hdl/buddy_allocator_tree.sv =====
// Buddy allocator tree top level: node state memory and the walk sequencer.
// Depends on bat_pkg and the channel interfaces in bat_channels.sv.
`timescale 1ns / 1ps

// Usage. Requests arrive as words on req_bus: an allocate carries a size in bytes,
// a free carries the byte offset of the block to release. Each request produces
// exactly one word on rsp_bus with the granted offset and a success flag.
// One request is in work at a time. The node states live in a memory with a
// read port and a separate write port and a registered read, so each tree node
// that is visited passes through a read state and an evaluate state. An allocate
// visits nodes in a depth-first search and splits one level at a time; a free
// walks down level by level and then makes a merge pass back to the root.
// After reset the memory is cleared in a pass, one node per cycle, that leaves
// the root idle; req_bus.ready stays low during that pass.
// The response sits in an output register. If the receiver stalls, the next
// request is still accepted and worked; it waits only when its own response is
// ready and the previous one has not been taken.

module buddy_allocator_tree (
   input logic       clock,
   input logic       reset,
   bat_req_if.sink   req_bus,
   bat_rsp_if.source rsp_bus
);

   localparam int NW = bat_pkg::NODE_W;
   localparam int LW = bat_pkg::LVL_W;
   localparam int UW = bat_pkg::UNIT_W;
   localparam int BW = bat_pkg::BYTE_W;
   localparam int AW = bat_pkg::ADDR_W;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_A_READ, S_A_EVAL, S_A_BACK, S_A_SPLIT0, S_A_SPLIT1,
      S_A_SPLIT2, S_A_MARK, S_F_READ, S_F_EVAL, S_UP_LO, S_UP_HI, S_UP_EVAL,
      S_UP_W1, S_UP_NEXT
   } state_type;

   // Node state memory.
   logic [1:0] mem [bat_pkg::NODE_COUNT];
   logic [1:0] rd_data_ff;
   logic [NW-1:0] rd_addr, wr_addr;
   logic [1:0] wr_data;
   logic wr_en;

   state_type state_ff, state_in;
   logic [NW-1:0] cur_ff, cur_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [LW-1:0] tgt_ff, tgt_in;
   logic [UW-1:0] start_ff, start_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [1:0] lo_st_ff, lo_st_in;
   logic found_ff, found_in;
   logic [AW-1:0] res_addr_ff, res_addr_in;
   logic res_ok_ff, res_ok_in;
   logic rsp_valid_ff, rsp_valid_in;
   bat_pkg::rsp_word_type rsp_word_ff, rsp_word_in;
   logic [NW-1:0] clr_ff, clr_in;
   logic [1:0] pass_ff, pass_in;

   logic [NW-1:0] lo_node, hi_node, parent_node;
   logic [UW-1:0] blk_units, half_units, mid_units;
   logic [BW-1:0] start_bytes, mid_bytes, addr_bytes;
   logic [LW-1:0] size_tgt;
   logic size_ok;

   assign lo_node     = NW'({cur_ff, 1'b0} + (NW + 1)'(1));
   assign hi_node     = NW'({cur_ff, 1'b0} + (NW + 1)'(2));
   assign parent_node = NW'((cur_ff - NW'(1)) >> 1);
   assign blk_units   = UW'(1) << lvl_ff;
   assign half_units  = blk_units >> 1;
   assign mid_units   = start_ff + half_units;
   assign start_bytes = BW'(start_ff) * BW'(bat_pkg::UNIT_BYTES);
   assign mid_bytes   = BW'(mid_units) * BW'(bat_pkg::UNIT_BYTES);
   assign addr_bytes  = BW'(addr_ff);

   // Smallest level whose block holds the requested size.
   always_comb begin
      logic [63:0] sz;
      sz = 64'(req_bus.word.request_size);
      size_tgt = LW'(bat_pkg::TOP_LEVEL);
      for (int t = bat_pkg::TOP_LEVEL; t >= 0; t--) begin
         if (sz <= (64'(bat_pkg::UNIT_BYTES) << t)) begin
            size_tgt = LW'(t);
         end
      end
      size_ok = (sz != 64'd0) &&
                (sz <= (64'(bat_pkg::UNIT_BYTES) << bat_pkg::TOP_LEVEL));
   end

   // The response for a finished request may be loaded when the output is free.
   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready = (state_ff == S_IDLE) && (pass_ff == 2'd0);
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.word  = rsp_word_ff;

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      lvl_in      = lvl_ff;
      tgt_in      = tgt_ff;
      start_in    = start_ff;
      addr_in     = addr_ff;
      lo_st_in    = lo_st_ff;
      found_in    = found_ff;
      res_addr_in = res_addr_ff;
      res_ok_in   = res_ok_ff;
      clr_in      = clr_ff;
      pass_in     = pass_ff;
      rd_addr     = cur_ff;
      wr_en       = 1'b0;
      wr_addr     = cur_ff;
      wr_data     = bat_pkg::ST_UNAVAIL;

      // Output register: drain when taken, load a finished result when free.
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_word_in  = rsp_word_ff;
      if (pass_ff == 2'd1 && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_word_in.granted_address = res_addr_ff;
         rsp_word_in.success = res_ok_ff;
         pass_in = 2'd0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = (clr_ff == NW'(0)) ? bat_pkg::ST_IDLE : bat_pkg::ST_UNAVAIL;
            clr_in  = clr_ff + NW'(1);
            if (clr_ff == NW'(bat_pkg::NODE_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_bus.valid && pass_ff == 2'd0) begin
               cur_in   = '0;
               lvl_in   = LW'(bat_pkg::TOP_LEVEL);
               start_in = '0;
               tgt_in   = size_tgt;
               addr_in  = req_bus.word.block_address;
               found_in = 1'b0;
               if (req_bus.word.operation == bat_pkg::OP_FREE) begin
                  state_in = S_F_READ;
               end else if (size_ok) begin
                  state_in = S_A_READ;
               end else begin
                  res_addr_in = '0;
                  res_ok_in   = 1'b0;
                  pass_in     = 2'd1;
               end
            end
         end
         S_A_READ: state_in = S_A_EVAL;
         S_A_EVAL: begin
            if (rd_data_ff == bat_pkg::ST_IDLE) begin
               if (lvl_ff == tgt_ff) begin
                  state_in = S_A_MARK;
               end else begin
                  state_in = S_A_SPLIT0;
               end
            end else if (rd_data_ff == bat_pkg::ST_ALLOC || lvl_ff == tgt_ff) begin
               state_in = S_A_BACK;
            end else begin
               cur_in   = lo_node;
               lvl_in   = lvl_ff - LW'(1);
               state_in = S_A_READ;
            end
         end
         S_A_BACK: begin
            // Move to the next subtree in address order.
            if (cur_ff == NW'(0)) begin
               res_addr_in = '0;
               res_ok_in   = 1'b0;
               pass_in     = 2'd1;
               state_in    = S_IDLE;
            end else if (cur_ff[0]) begin
               cur_in   = cur_ff + NW'(1);
               start_in = start_ff + blk_units;
               state_in = S_A_READ;
            end else begin
               cur_in   = parent_node;
               lvl_in   = lvl_ff + LW'(1);
               start_in = start_ff - blk_units;
            end
         end
         S_A_SPLIT0: begin
            wr_en    = 1'b1;
            wr_data  = bat_pkg::ST_UNAVAIL;
            state_in = S_A_SPLIT1;
         end
         S_A_SPLIT1: begin
            wr_en    = 1'b1;
            wr_addr  = lo_node;
            wr_data  = bat_pkg::ST_IDLE;
            state_in = S_A_SPLIT2;
         end
         S_A_SPLIT2: begin
            wr_en   = 1'b1;
            wr_addr = hi_node;
            wr_data = bat_pkg::ST_IDLE;
            cur_in  = lo_node;
            lvl_in  = lvl_ff - LW'(1);
            state_in = (lvl_ff - LW'(1) == tgt_ff) ? S_A_MARK : S_A_SPLIT0;
         end
         S_A_MARK: begin
            wr_en       = 1'b1;
            wr_data     = bat_pkg::ST_ALLOC;
            res_addr_in = start_bytes[AW-1:0];
            res_ok_in   = 1'b1;
            pass_in     = 2'd1;
            state_in    = S_IDLE;
         end
         S_F_READ: state_in = S_F_EVAL;
         S_F_EVAL: begin
            if (start_bytes == addr_bytes && rd_data_ff == bat_pkg::ST_ALLOC) begin
               wr_en    = 1'b1;
               wr_data  = bat_pkg::ST_IDLE;
               found_in = 1'b1;
               state_in = S_UP_NEXT;
            end else if (lvl_ff == LW'(0)) begin
               state_in = S_UP_NEXT;
            end else begin
               lvl_in = lvl_ff - LW'(1);
               if (addr_bytes < mid_bytes) begin
                  cur_in = lo_node;
               end else begin
                  cur_in   = hi_node;
                  start_in = mid_units;
               end
               state_in = S_F_READ;
            end
         end
         S_UP_NEXT: begin
            // Climb one level; at the root the free is finished.
            if (cur_ff == NW'(0)) begin
               res_addr_in = '0;
               res_ok_in   = found_ff;
               pass_in     = 2'd1;
               state_in    = S_IDLE;
            end else begin
               cur_in   = parent_node;
               state_in = S_UP_LO;
            end
         end
         S_UP_LO: begin
            rd_addr  = lo_node;
            state_in = S_UP_HI;
         end
         S_UP_HI: begin
            rd_addr  = hi_node;
            lo_st_in = rd_data_ff;
            state_in = S_UP_EVAL;
         end
         S_UP_EVAL: begin
            if (lo_st_ff == bat_pkg::ST_IDLE && rd_data_ff == bat_pkg::ST_IDLE) begin
               wr_en    = 1'b1;
               wr_data  = bat_pkg::ST_IDLE;
               state_in = S_UP_W1;
            end else begin
               state_in = S_UP_NEXT;
            end
         end
         S_UP_W1: begin
            // Lower child first, then upper child.
            wr_en   = 1'b1;
            wr_data = bat_pkg::ST_UNAVAIL;
            if (lo_st_ff == bat_pkg::ST_IDLE) begin
               wr_addr  = lo_node;
               lo_st_in = bat_pkg::ST_UNAVAIL;
            end else begin
               wr_addr  = hi_node;
               state_in = S_UP_NEXT;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pass_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      lvl_ff      <= lvl_in;
      tgt_ff      <= tgt_in;
      start_ff    <= start_in;
      addr_ff     <= addr_in;
      lo_st_ff    <= lo_st_in;
      found_ff    <= found_in;
      res_addr_ff <= res_addr_in;
      res_ok_ff   <= res_ok_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule

// ===== tb/sv/tb_buddy_allocator_tree.sv =====
// Self-checking testbench for the buddy allocator tree: directed and random
// allocate/free words, checked against a tree predictor. Depends on bat_pkg and bat_channels.sv.
`timescale 1ns / 1ps

module tb_buddy_allocator_tree;

   localparam int POOL_BYTES  = bat_pkg::UNIT_BYTES << bat_pkg::TOP_LEVEL;
   localparam int CYCLE_LIMIT = 40_000_000;
   localparam int HOLD_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bat_req_if req_bus ();
   bat_rsp_if rsp_bus ();

   buddy_allocator_tree i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   // 4 ns clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predicted node states, one 2-bit code per tree node, and the words that the
   // block still owes us, oldest first.
   logic [1:0]   tree_state [bat_pkg::NODE_COUNT];
   bat_pkg::rsp_word_type pending_grants [$];
   // Start offsets of blocks that the predictor believes are allocated. The random
   // phases free from this list so that most frees hit a real block.
   int           live_blocks [$];

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int error_count  = 0;
   int words_sent   = 0;
   int words_checked = 0;
   int grants_seen  = 0;
   longint cycle_count = 0;

   // Long receiver hold-off: the test raises hold_req, the receiver process counts
   // the stretch and reports hold_done when it is over.
   logic hold_req  = 1'b0;
   logic hold_done = 1'b0;
   int   hold_count = 0;

   function automatic void clear_tree();
      for (int i = 0; i < bat_pkg::NODE_COUNT; i++) tree_state[i] = bat_pkg::ST_UNAVAIL;
      tree_state[0] = bat_pkg::ST_IDLE;
   endfunction

   // Depth-first search for the lowest idle block at the target level. Idle nodes
   // on the way down are split so that both halves become idle.
   function automatic bit claim_block(int level, int target, int node, int start,
                                      output int found);
      int lo;
      int hi;
      found = 0;
      if (level < target || node >= bat_pkg::NODE_COUNT) return 1'b0;
      if (tree_state[node] == bat_pkg::ST_ALLOC) return 1'b0;
      if (level == target && tree_state[node] == bat_pkg::ST_IDLE) begin
         tree_state[node] = bat_pkg::ST_ALLOC;
         found = start;
         return 1'b1;
      end
      if (level == 0) return 1'b0;
      lo = 2 * node + 1;
      hi = 2 * node + 2;
      if (hi >= bat_pkg::NODE_COUNT) return 1'b0;
      if (tree_state[node] == bat_pkg::ST_IDLE) begin
         tree_state[node] = bat_pkg::ST_UNAVAIL;
         tree_state[lo]   = bat_pkg::ST_IDLE;
         tree_state[hi]   = bat_pkg::ST_IDLE;
      end
      if (claim_block(level - 1, target, lo, start, found)) return 1'b1;
      return claim_block(level - 1, target, hi,
                         start + ((bat_pkg::UNIT_BYTES << level) >> 1), found);
   endfunction

   // Walks toward the block at addr by comparing against each node's midpoint,
   // frees it if allocated, and merges idle buddies on the way back up.
   function automatic bit release_walk(int level, int node, int start, int addr);
      int lo;
      int hi;
      int half;
      bit hit;
      if (node >= bat_pkg::NODE_COUNT) return 1'b0;
      if (start == addr && tree_state[node] == bat_pkg::ST_ALLOC) begin
         tree_state[node] = bat_pkg::ST_IDLE;
         return 1'b1;
      end
      if (level == 0) return 1'b0;
      lo = 2 * node + 1;
      hi = 2 * node + 2;
      if (hi >= bat_pkg::NODE_COUNT) return 1'b0;
      half = (bat_pkg::UNIT_BYTES << level) >> 1;
      if (addr < start + half) hit = release_walk(level - 1, lo, start, addr);
      else                     hit = release_walk(level - 1, hi, start + half, addr);
      if (tree_state[lo] == bat_pkg::ST_IDLE && tree_state[hi] == bat_pkg::ST_IDLE) begin
         tree_state[node] = bat_pkg::ST_IDLE;
         tree_state[lo]   = bat_pkg::ST_UNAVAIL;
         tree_state[hi]   = bat_pkg::ST_UNAVAIL;
      end
      return hit;
   endfunction

   // Expected response word for one accepted request; updates the predicted tree.
   function automatic bat_pkg::rsp_word_type predict_grant(bat_pkg::req_word_type w);
      bat_pkg::rsp_word_type r;
      int target;
      int where;
      r = '0;
      where = 0;
      if (w.operation == bat_pkg::OP_ALLOC) begin
         if (w.request_size != 0 && int'(w.request_size) <= POOL_BYTES) begin
            target = 0;
            while (target < bat_pkg::TOP_LEVEL &&
                   (bat_pkg::UNIT_BYTES << target) < int'(w.request_size))
               target++;
            r.success = claim_block(bat_pkg::TOP_LEVEL, target, 0, 0, where);
            if (r.success) begin
               r.granted_address = where[bat_pkg::ADDR_W-1:0];
               live_blocks.push_back(where);
            end
         end
      end else begin
         r.success = release_walk(bat_pkg::TOP_LEVEL, 0, 0, int'(w.block_address));
         if (r.success)
            foreach (live_blocks[i])
               if (live_blocks[i] == int'(w.block_address)) begin
                  live_blocks.delete(i);
                  break;
               end
      end
      return r;
   endfunction

   // Offers one word, with random idle cycles ahead of it, and records the
   // expected response once the block accepts it.
   task automatic send_word(logic op, logic [bat_pkg::SIZE_W-1:0] size,
                            logic [bat_pkg::ADDR_W-1:0] addr);
      bat_pkg::req_word_type w;
      w.operation     = op;
      w.request_size  = size;
      w.block_address = addr;
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.word  <= w;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      pending_grants.push_back(predict_grant(w));
      words_sent++;
   endtask

   task automatic send_alloc(int size);
      send_word(bat_pkg::OP_ALLOC, size[bat_pkg::SIZE_W-1:0], bat_pkg::ADDR_W'($urandom));
   endtask

   task automatic send_free(int addr);
      send_word(bat_pkg::OP_FREE, bat_pkg::SIZE_W'($urandom), addr[bat_pkg::ADDR_W-1:0]);
   endtask

   // Lowers valid and waits until every expected response has arrived.
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_grants.size() != 0) @(posedge clock);
   endtask

   // Size draw weighted toward small blocks so the tree gets deep, with the
   // occasional large, zero or oversize request.
   function automatic int pick_size();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55) return $urandom_range(1, 16);
      if (roll < 80) return $urandom_range(17, 128);
      if (roll < 92) return $urandom_range(129, POOL_BYTES);
      if (roll < 95) return 0;
      return $urandom_range(POOL_BYTES + 1, 65535);
   endfunction

   // Zero and oversize requests, the smallest and largest sizes, rounding to the
   // next power of two, and a free of the whole pool.
   task automatic test_size_extremes();
      send_alloc(0);
      send_alloc(65535);
      send_alloc(POOL_BYTES + 1);
      send_alloc(POOL_BYTES);
      send_alloc(1);
      send_free(0);
      send_alloc(1);
      send_alloc(3);
      send_alloc(5);
      send_alloc(512);
      send_free(4);
      send_free(8);
      send_free(512);
      send_free(0);
   endtask

   // Fill the pool with four quarters, then a request that cannot fit, then free
   // everything, with bad frees mixed in: unaligned, never allocated, twice.
   task automatic test_full_pool_and_bad_frees();
      for (int i = 0; i < 4; i++) send_alloc(POOL_BYTES / 4);
      send_alloc(1);
      send_free(1);
      send_free(1023);
      send_free(256);
      send_free(256);
      send_free(0);
      send_free(512);
      send_free(768);
      send_free(0);
   endtask

   task automatic test_random_mix(int count, int tx_pct, int rx_pct);
      int roll;
      req_idle_pct = tx_pct;
      rsp_idle_pct = rx_pct;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 55)
            send_alloc(pick_size());
         else if (roll < 90 && live_blocks.size() != 0)
            send_free(live_blocks[$urandom_range(live_blocks.size() - 1)]);
         else if (roll < 95)
            send_word(1'($urandom_range(1)), bat_pkg::SIZE_W'($urandom),
                      bat_pkg::ADDR_W'($urandom));
         else
            send_free(int'($urandom_range(POOL_BYTES - 1)));
      end
   endtask

   // The receiver holds off for a long stretch while words keep coming, so the
   // output register fills and the block has to stall its input.
   task automatic test_receiver_hold_off();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_req <= 1'b1;
      for (int n = 0; n < 6; n++) send_alloc($urandom_range(1, 8));
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (!hold_done) @(posedge clock);
      hold_req <= 1'b0;
      wait_for_drain();
      while (live_blocks.size() != 0) send_free(live_blocks[0]);
      wait_for_drain();
   endtask

   // Receiver: random ready, or held low through a counted hold-off stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_count    <= 0;
         hold_done     <= 1'b0;
      end else if (hold_req && !hold_done) begin
         rsp_bus.ready <= 1'b0;
         hold_count    <= hold_count + 1;
         if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         if (!hold_req) begin
            hold_count <= 0;
            hold_done  <= 1'b0;
         end
      end
   end

   // Checker: each accepted response word is compared with the oldest expectation.
   always @(posedge clock) begin
      bat_pkg::rsp_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_grants.size() == 0) begin
            $error("unexpected response word: granted_address %0d success %0b",
                   rsp_bus.word.granted_address, rsp_bus.word.success);
            error_count++;
         end else begin
            want = pending_grants.pop_front();
            if (rsp_bus.word.granted_address !== want.granted_address) begin
               $error("granted_address: expected %0d, actual %0d",
                      want.granted_address, rsp_bus.word.granted_address);
               error_count++;
            end
            if (rsp_bus.word.success !== want.success) begin
               $error("success: expected %0b, actual %0b",
                      want.success, rsp_bus.word.success);
               error_count++;
            end
            if (want.success) grants_seen++;
            words_checked++;
         end
      end
   end

   // Watchdog. The limit covers the clearing pass plus worst-case searches for
   // every word, several times over.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still expected",
                  cycle_count, pending_grants.size());
         $display("tb_buddy_allocator_tree: errors");
         $finish;
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.word  = '0;
      clear_tree();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_size_extremes();
      test_full_pool_and_bad_frees();
      // The sender waits here for every expected response before going on.
      wait_for_drain();
      test_random_mix(170, 17, 67);
      test_random_mix(170, 67, 17);
      test_random_mix(170, 0, 0);
      wait_for_drain();
      test_receiver_hold_off();

      repeat (200) @(posedge clock);
      $display("covered %0d request words, %0d responses checked, %0d successful",
               words_sent, words_checked, grants_seen);
      $display("extremes, full pool, bad frees, random mixes and a long output stall");
      if (error_count == 0 && pending_grants.size() == 0) begin
         $display("tb_buddy_allocator_tree: clean");
      end else begin
         $display("tb_buddy_allocator_tree: errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/bat_pkg.sv
hdl/bat_channels.sv
hdl/buddy_allocator_tree.sv
tb/sv/tb_buddy_allocator_tree.sv
